@@ src/itda_pkg.sv @@
//------------------------------------------------------------------------------
// itda_pkg
// Shared constants and types for the integer to decimal ASCII converter.
//------------------------------------------------------------------------------
`default_nettype none

package itda_pkg;

  localparam int VALUE_WIDTH_DEF = 32;
  localparam int DIGIT_W         = 4;
  localparam int CHAR_W          = 6;

  localparam logic [CHAR_W-1:0] CHAR_ZERO  = 6'd48;
  localparam logic [CHAR_W-1:0] CHAR_MINUS = 6'd45;
  localparam logic [CHAR_W-1:0] CHAR_NINE  = 6'd57;

  typedef struct packed {
    logic load;
    logic shift_digit;
  } itda_ctl_t;

endpackage

`default_nettype wire

@@ src/itda_dabble.sv @@
//------------------------------------------------------------------------------
// itda_dabble
// Bit-serial binary to BCD converter using the shift and add-three method.
// The magnitude enters one bit per cycle while busy; the BCD digits leave one per cycle on each shift_digit request.
//------------------------------------------------------------------------------
`default_nettype none

module itda_dabble
  import itda_pkg::*;
#(
  parameter int VALUE_WIDTH = VALUE_WIDTH_DEF
) (
  input  wire logic                   clk,
  input  wire logic                   rst_n,
  input  wire itda_ctl_t              ctl,
  input  wire logic [VALUE_WIDTH-1:0] load_value,
  output logic                        busy,
  output logic [DIGIT_W-1:0]          top_digit
);

  localparam int NDIG = (3 * VALUE_WIDTH + 9) / 10;
  localparam int BCDW = NDIG * DIGIT_W;
  localparam int BW   = $clog2(VALUE_WIDTH + 1);

  logic [VALUE_WIDTH-1:0] mag_r;
  logic [BCDW-1:0]        bcd_r;
  logic [BCDW-1:0]        bcd_adj;
  logic [BW-1:0]          bits_left_r;
  logic                   busy_r;

  always_comb begin
    for (int i = 0; i < NDIG; i++) begin
      if (bcd_r[i*DIGIT_W +: DIGIT_W] >= 4'd5) begin
        bcd_adj[i*DIGIT_W +: DIGIT_W] = bcd_r[i*DIGIT_W +: DIGIT_W] + 4'd3;
      end else begin
        bcd_adj[i*DIGIT_W +: DIGIT_W] = bcd_r[i*DIGIT_W +: DIGIT_W];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r      <= 1'b0;
      bits_left_r <= '0;
    end else if (ctl.load) begin
      busy_r      <= 1'b1;
      bits_left_r <= BW'(VALUE_WIDTH);
    end else if (busy_r) begin
      bits_left_r <= bits_left_r - BW'(1);
      if (bits_left_r == BW'(1)) begin
        busy_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (ctl.load) begin
      mag_r <= load_value[VALUE_WIDTH-1] ? (~load_value + VALUE_WIDTH'(1)) : load_value;
      bcd_r <= '0;
    end else if (busy_r) begin
      mag_r <= {mag_r[VALUE_WIDTH-2:0], 1'b0};
      bcd_r <= {bcd_adj[BCDW-2:0], mag_r[VALUE_WIDTH-1]};
    end else if (ctl.shift_digit) begin
      bcd_r <= {bcd_r[BCDW-DIGIT_W-1:0], {DIGIT_W{1'b0}}};
    end
  end

  assign busy      = busy_r;
  assign top_digit = bcd_r[BCDW-1 -: DIGIT_W];

endmodule

`default_nettype wire

@@ src/itda_seq.sv @@
//------------------------------------------------------------------------------
// itda_seq
// Sequencer: takes a word, runs the converter, drops leading zeros and sends
// the sign and the digits through the output register.
//------------------------------------------------------------------------------
`default_nettype none

module itda_seq
  import itda_pkg::*;
#(
  parameter int VALUE_WIDTH = VALUE_WIDTH_DEF
) (
  input  wire logic                   clk,
  input  wire logic                   rst_n,
  input  wire logic                   in_valid,
  output logic                        in_stall,
  input  wire logic [VALUE_WIDTH-1:0] in_value,
  output logic                        out_valid,
  input  wire logic                   out_stall,
  output logic [CHAR_W-1:0]           out_text_char,
  output logic                        out_last_char,
  output itda_ctl_t                   ctl,
  input  wire logic                   conv_busy,
  input  wire logic [DIGIT_W-1:0]     top_digit
);

  localparam int NDIG = (3 * VALUE_WIDTH + 9) / 10;
  localparam int CW   = $clog2(NDIG + 1);

  typedef enum logic [4:0] {
    ST_IDLE = 5'b00001,
    ST_CONV = 5'b00010,
    ST_SKIP = 5'b00100,
    ST_SIGN = 5'b01000,
    ST_EMIT = 5'b10000
  } state_t;

  state_t            state_r, state_nxt;
  logic              neg_r, neg_nxt;
  logic [CW-1:0]     digits_left_r, digits_left_nxt;
  logic              out_valid_r, out_valid_nxt;
  logic [CHAR_W-1:0] out_char_r, out_char_nxt;
  logic              out_last_r, out_last_nxt;
  logic              slot_free;
  logic              accept;

  assign slot_free = !out_valid_r || !out_stall;
  assign in_stall  = (state_r != ST_IDLE);
  assign accept    = in_valid && (state_r == ST_IDLE);

  always_comb begin
    state_nxt       = state_r;
    neg_nxt         = neg_r;
    digits_left_nxt = digits_left_r;
    out_valid_nxt   = out_valid_r && out_stall;
    out_char_nxt    = out_char_r;
    out_last_nxt    = out_last_r;
    ctl             = '0;
    unique case (state_r)
      ST_IDLE: begin
        if (accept) begin
          ctl.load  = 1'b1;
          neg_nxt   = in_value[VALUE_WIDTH-1];
          state_nxt = ST_CONV;
        end
      end
      ST_CONV: begin
        if (!conv_busy) begin
          digits_left_nxt = CW'(NDIG);
          state_nxt       = ST_SKIP;
        end
      end
      ST_SKIP: begin
        if (top_digit == '0 && digits_left_r > CW'(1)) begin
          ctl.shift_digit = 1'b1;
          digits_left_nxt = digits_left_r - CW'(1);
        end else begin
          state_nxt = neg_r ? ST_SIGN : ST_EMIT;
        end
      end
      ST_SIGN: begin
        if (slot_free) begin
          out_valid_nxt = 1'b1;
          out_char_nxt  = CHAR_MINUS;
          out_last_nxt  = 1'b0;
          state_nxt     = ST_EMIT;
        end
      end
      ST_EMIT: begin
        if (slot_free) begin
          out_valid_nxt   = 1'b1;
          out_char_nxt    = CHAR_ZERO + CHAR_W'(top_digit);
          out_last_nxt    = (digits_left_r == CW'(1));
          ctl.shift_digit = 1'b1;
          digits_left_nxt = digits_left_r - CW'(1);
          if (digits_left_r == CW'(1)) begin
            state_nxt = ST_IDLE;
          end
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r       <= ST_IDLE;
      out_valid_r   <= 1'b0;
      digits_left_r <= '0;
    end else begin
      state_r       <= state_nxt;
      out_valid_r   <= out_valid_nxt;
      digits_left_r <= digits_left_nxt;
    end
  end

  always_ff @(posedge clk) begin
    neg_r      <= neg_nxt;
    out_char_r <= out_char_nxt;
    out_last_r <= out_last_nxt;
  end

  assign out_valid     = out_valid_r;
  assign out_text_char = out_char_r;
  assign out_last_char = out_last_r;

endmodule

`default_nettype wire

@@ src/int_to_decimal_ascii_top.sv @@
// The first character follows the bit-serial conversion of a taken word and the
// dropping of leading zeros (up to NDIG - 1, nine at 32 bits). A new word is
// taken only once the last character of the previous one has been issued; the
// output gives one character per cycle while out_stall is low, after a minus
// sign for a negative word. Reset is synchronous and active
// low; it empties the output register and returns the sequencer to idle.
//------------------------------------------------------------------------------
// int_to_decimal_ascii_top
// Converts a signed integer into its ASCII decimal text, one character per
// output word, with the last character flagged.
//------------------------------------------------------------------------------
`default_nettype none

module int_to_decimal_ascii_top
  import itda_pkg::*;
#(
  parameter int VALUE_WIDTH = VALUE_WIDTH_DEF
) (
  input  wire logic                   clk,
  input  wire logic                   rst_n,
  input  wire logic                   in_valid,
  output logic                        in_stall,
  input  wire logic [VALUE_WIDTH-1:0] in_value,
  output logic                        out_valid,
  input  wire logic                   out_stall,
  output logic [CHAR_W-1:0]           out_text_char,
  output logic                        out_last_char
);

  itda_ctl_t            ctl;
  logic                 conv_busy;
  logic [DIGIT_W-1:0]   top_digit;

  itda_dabble #(
    .VALUE_WIDTH(VALUE_WIDTH)
  ) u_dabble (
    .clk        (clk),
    .rst_n      (rst_n),
    .ctl        (ctl),
    .load_value (in_value),
    .busy       (conv_busy),
    .top_digit  (top_digit)
  );

  itda_seq #(
    .VALUE_WIDTH(VALUE_WIDTH)
  ) u_seq (
    .clk           (clk),
    .rst_n         (rst_n),
    .in_valid      (in_valid),
    .in_stall      (in_stall),
    .in_value      (in_value),
    .out_valid     (out_valid),
    .out_stall     (out_stall),
    .out_text_char (out_text_char),
    .out_last_char (out_last_char),
    .ctl           (ctl),
    .conv_busy     (conv_busy),
    .top_digit     (top_digit)
  );

  a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && !in_stall |=> in_stall)
    else $error("input taken again right after a word was accepted");

  a_char_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (out_text_char == CHAR_MINUS ||
                   (out_text_char >= CHAR_ZERO && out_text_char <= CHAR_NINE)))
    else $error("output character is neither a digit nor a minus sign");

  a_minus_not_last: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_text_char == CHAR_MINUS |-> !out_last_char)
    else $error("minus sign flagged as the last character");

endmodule

`default_nettype wire
